// ===== hdl/kdt_pkg.sv =====
// Shared types and constants for the keyed dense table.
`default_nettype none

package kdt_pkg;

  localparam int CAPACITY_DEF      = 256;
  localparam int PAYLOAD_WIDTH_DEF = 64;

  typedef enum logic [2:0] {
    KIND_UPSERT  = 3'd0,
    KIND_FIND    = 3'd1,
    KIND_RM_KEY  = 3'd2,
    KIND_RM_SLOT = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/kdt_cell.sv =====
// One entry of the rotating table: key and payload, loaded from the neighbor on shift.
`default_nettype none

module kdt_cell #(
  parameter int PayloadWidth = kdt_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    shift_i,
  input  wire logic [31:0]             key_i,
  input  wire logic [PayloadWidth-1:0] pay_i,
  output logic      [31:0]             key_o,
  output logic      [PayloadWidth-1:0] pay_o
);

  logic [31:0]             key_q;
  logic [PayloadWidth-1:0] pay_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= key_i;
      pay_q <= pay_i;
    end
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

`default_nettype wire

// ===== hdl/kdt_ctrl.sv =====
// Sequencer: request latch, head compare and rewrite, result and output registers.
`default_nettype none

module kdt_ctrl #(
  parameter int Capacity     = kdt_pkg::CAPACITY_DEF,
  parameter int PayloadWidth = kdt_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [2:0]              kind_i,
  input  wire logic signed [31:0]      key_i,
  input  wire logic [63:0]             payload_i,
  input  wire logic [7:0]              slot_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic      [2:0]              status_o,
  output logic      [7:0]              position_o,
  output logic      [63:0]             data_out_o,
  output logic      [8:0]              occupancy_o,
  output logic                         shift_o,
  input  wire logic [31:0]             head_key_i,
  input  wire logic [PayloadWidth-1:0] head_pay_i,
  output logic      [31:0]             tail_key_o,
  output logic      [PayloadWidth-1:0] tail_pay_o
);

  localparam int CntW  = $clog2(Capacity + 1);
  localparam int StepW = $clog2(Capacity);
  localparam int CmpW  = (CntW > 8) ? CntW : 8;

  kdt_pkg::state_e  state_q, state_d;
  kdt_pkg::status_e stat_q, stat_d;
  kdt_pkg::status_e out_stat_q;

  logic [StepW-1:0]        step_q;
  logic [CntW-1:0]         count_q, count_d;
  logic                    hit_q, ins_q;
  logic [2:0]              kind_q;
  logic [31:0]             req_key_q;
  logic [PayloadWidth-1:0] req_pay_q;
  logic [CmpW-1:0]         req_slot_q;
  logic [StepW-1:0]        pos_q;
  logic [PayloadWidth-1:0] data_q;
  logic [31:0]             last_key_q, cand_key_q;
  logic [PayloadWidth-1:0] last_pay_q, cand_pay_q;
  logic                    out_valid_q;
  logic [7:0]              out_pos_q;
  logic [63:0]             out_data_q;
  logic [8:0]              out_occ_q;

  logic            in_acc, scan, last_step, out_load;
  logic [CntW-1:0] step_ext;
  logic            live, match, slot_hit, do_update, do_insert, do_found, do_remove;
  logic            is_rm, at_last_entry, at_cand, hit_e, ins_e;

  assign in_stall_o = (state_q != kdt_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign scan       = (state_q == kdt_pkg::S_SCAN);
  assign shift_o    = scan;
  assign last_step  = scan && (step_q == StepW'(Capacity - 1));
  assign out_load   = (state_q == kdt_pkg::S_RESP) && (!out_valid_q || !out_stall_i);

  // head of the ring holds the entry at slot step_q
  assign step_ext  = CntW'(step_q);
  assign live      = step_ext < count_q;
  assign is_rm     = (kind_q == kdt_pkg::KIND_RM_KEY) || (kind_q == kdt_pkg::KIND_RM_SLOT);
  assign match     = scan && live && !hit_q && (head_key_i == req_key_q);
  assign slot_hit  = scan && !hit_q && (CmpW'(step_q) == req_slot_q)
                     && (req_slot_q < CmpW'(count_q));
  assign do_update = (kind_q == kdt_pkg::KIND_UPSERT) && match;
  assign do_found  = (kind_q == kdt_pkg::KIND_FIND) && match;
  assign do_remove = ((kind_q == kdt_pkg::KIND_RM_KEY) && match)
                     || ((kind_q == kdt_pkg::KIND_RM_SLOT) && slot_hit);
  assign do_insert = scan && (kind_q == kdt_pkg::KIND_UPSERT) && !hit_q
                     && (step_ext == count_q) && (count_q != CntW'(Capacity));
  assign at_last_entry = (step_ext == count_q - CntW'(1));
  assign at_cand       = (count_q > CntW'(1)) && (step_ext == count_q - CntW'(2));
  assign hit_e = hit_q || do_update || do_found || do_remove;
  assign ins_e = ins_q || do_insert;

  // rewrite the entry leaving the head: new payload, new entry, or the last entry into the hole
  always_comb begin
    tail_key_o = head_key_i;
    tail_pay_o = head_pay_i;
    if (do_insert) begin
      tail_key_o = req_key_q;
      tail_pay_o = req_pay_q;
    end else if (do_update) begin
      tail_pay_o = req_pay_q;
    end else if (do_remove) begin
      tail_key_o = last_key_q;
      tail_pay_o = last_pay_q;
    end
  end

  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    count_d = count_q;
    case (state_q)
      kdt_pkg::S_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            kdt_pkg::KIND_UPSERT, kdt_pkg::KIND_FIND,
            kdt_pkg::KIND_RM_KEY, kdt_pkg::KIND_RM_SLOT: begin
              state_d = kdt_pkg::S_SCAN;
            end
            kdt_pkg::KIND_CLEAR: begin
              count_d = '0;
              stat_d  = kdt_pkg::ST_CLEARED;
              state_d = kdt_pkg::S_RESP;
            end
            default: begin
              stat_d  = kdt_pkg::ST_MISS;
              state_d = kdt_pkg::S_RESP;
            end
          endcase
        end
      end
      kdt_pkg::S_SCAN: begin
        if (last_step) begin
          state_d = kdt_pkg::S_RESP;
          case (kind_q)
            kdt_pkg::KIND_UPSERT: begin
              if (hit_e) begin
                stat_d = kdt_pkg::ST_HIT;
              end else if (ins_e) begin
                stat_d  = kdt_pkg::ST_INSERTED;
                count_d = count_q + CntW'(1);
              end else begin
                stat_d = kdt_pkg::ST_FULL;
              end
            end
            kdt_pkg::KIND_FIND: begin
              stat_d = hit_e ? kdt_pkg::ST_HIT : kdt_pkg::ST_MISS;
            end
            default: begin
              if (hit_e) begin
                stat_d  = kdt_pkg::ST_REMOVED;
                count_d = count_q - CntW'(1);
              end else begin
                stat_d = kdt_pkg::ST_MISS;
              end
            end
          endcase
        end
      end
      kdt_pkg::S_RESP: begin
        if (out_load) begin
          state_d = kdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kdt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kdt_pkg::S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (in_acc) begin
        step_q <= '0;
        hit_q  <= 1'b0;
        ins_q  <= 1'b0;
      end else if (scan) begin
        step_q <= step_q + StepW'(1);
        if (do_update || do_found || do_remove) begin
          hit_q <= 1'b1;
        end
        if (do_insert) begin
          ins_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    if (in_acc) begin
      kind_q     <= kind_i;
      req_key_q  <= key_i;
      req_pay_q  <= payload_i[PayloadWidth-1:0];
      req_slot_q <= CmpW'(slot_i);
      pos_q      <= '0;
      data_q     <= '0;
    end else if (scan) begin
      if (do_update || do_found || do_remove || do_insert) begin
        pos_q <= step_q;
      end
      if (do_found) begin
        data_q <= head_pay_i;
      end else if (do_update || do_insert) begin
        data_q <= req_pay_q;
      end
      // track the entry that sits at the last slot after this request
      if (do_insert || ((kind_q == kdt_pkg::KIND_UPSERT) && at_last_entry)) begin
        last_key_q <= tail_key_o;
        last_pay_q <= tail_pay_o;
      end
      if (is_rm && at_cand) begin
        cand_key_q <= tail_key_o;
        cand_pay_q <= tail_pay_o;
      end
      if (last_step && is_rm && hit_e) begin
        last_key_q <= cand_key_q;
        last_pay_q <= cand_pay_q;
      end
    end
    if (out_load) begin
      out_stat_q <= stat_q;
      out_pos_q  <= 8'(pos_q);
      out_data_q <= 64'(data_q);
      out_occ_q  <= 9'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign position_o  = out_pos_q;
  assign data_out_o  = out_data_q;
  assign occupancy_o = out_occ_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_step |=> (state_q == kdt_pkg::S_RESP))
    else $error("scan did not end after a full rotation");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!last_step && !(in_acc && (kind_i == kdt_pkg::KIND_CLEAR))) |=> $stable(count_q))
    else $error("entry count changed outside request completion");

  a_hit_ins_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hit_q && ins_q))
    else $error("request both matched and inserted");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == kdt_pkg::S_RESP))
    else $error("result raised without a completed request");

endmodule

`default_nettype wire

// ===== hdl/keyed_dense_table_swap_remove_core.sv =====
// Top level: ring of entry cells and the request sequencer.
// Upsert, find and both removals finish after one full rotation of the cell ring past the
// single head compare; clear and unused kinds skip the scan and go straight to the response.
// The sequencer stalls new requests until the current one has been moved to the output
// register, where results wait while the receiver stalls.
// Reset: entry count and control clear at once; cell contents stay unknown until written.
`default_nettype none

module keyed_dense_table_swap_remove_core #(
  parameter int Capacity     = kdt_pkg::CAPACITY_DEF,
  parameter int PayloadWidth = kdt_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         kind_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic [63:0]        payload_i,
  input  wire logic [7:0]         slot_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [2:0]         status_o,
  output logic      [7:0]         position_o,
  output logic      [63:0]        data_out_o,
  output logic      [8:0]         occupancy_o
);

  logic                    shift;
  logic [31:0]             tail_key;
  logic [PayloadWidth-1:0] tail_pay;
  logic [31:0]             cell_key [Capacity];
  logic [PayloadWidth-1:0] cell_pay [Capacity];

  kdt_ctrl #(
    .Capacity    (Capacity),
    .PayloadWidth(PayloadWidth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .key_i      (key_i),
    .payload_i  (payload_i),
    .slot_i     (slot_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .position_o (position_o),
    .data_out_o (data_out_o),
    .occupancy_o(occupancy_o),
    .shift_o    (shift),
    .head_key_i (cell_key[0]),
    .head_pay_i (cell_pay[0]),
    .tail_key_o (tail_key),
    .tail_pay_o (tail_pay)
  );

  // cell i takes from cell i+1; the last cell takes the rewritten head entry
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    if (i == Capacity - 1) begin : g_tail
      kdt_cell #(
        .PayloadWidth(PayloadWidth)
      ) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .key_i  (tail_key),
        .pay_i  (tail_pay),
        .key_o  (cell_key[i]),
        .pay_o  (cell_pay[i])
      );
    end else begin : g_body
      kdt_cell #(
        .PayloadWidth(PayloadWidth)
      ) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .key_i  (cell_key[i+1]),
        .pay_i  (cell_pay[i+1]),
        .key_o  (cell_key[i]),
        .pay_o  (cell_pay[i])
      );
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the keyed dense table: upsert, find, swap-remove and clear.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kdt_pkg::*;

  localparam int CAP           = kdt_pkg::CAPACITY_DEF;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int RANDOM_ITEMS  = 260;
  localparam int POOL_SIZE     = 32;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    status_e     status;
    logic [7:0]  position;
    logic [63:0] data;
    logic [8:0]  occupancy;
  } table_reply_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [2:0]         kind      = KIND_FIND;
  logic signed [31:0] key       = '0;
  logic [63:0]        payload   = '0;
  logic [7:0]         slot      = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [7:0]         position;
  logic [63:0]        data_out;
  logic [8:0]         occupancy;

  // Predicted table contents
  logic signed [31:0] tbl_keys [CAP];
  logic [63:0]        tbl_data [CAP];
  int                 tbl_count = 0;

  table_reply_t       pending[$];
  logic signed [31:0] key_pool [POOL_SIZE];
  bit                 calm_phase = 1'b0;
  int                 fail_count = 0;
  int                 sent_count = 0;
  int                 reply_count = 0;
  int                 status_tally [8];
  int                 idle_cycles = 0;

  keyed_dense_table_swap_remove_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .key_i       (key),
    .payload_i   (payload),
    .slot_i      (slot),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .position_o  (position),
    .data_out_o  (data_out),
    .occupancy_o (occupancy)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int find_key(input logic signed [31:0] k);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Fill the hole with the last entry, then shrink
  function automatic void drop_entry(input int at);
    int last;
    last = tbl_count - 1;
    if (at != last) begin
      tbl_keys[at] = tbl_keys[last];
      tbl_data[at] = tbl_data[last];
    end
    tbl_count = last;
  endfunction

  function automatic table_reply_t apply_request(input logic [2:0] k_kind,
                                                 input logic signed [31:0] k_key,
                                                 input logic [63:0] k_pay,
                                                 input logic [7:0] k_slot);
    table_reply_t r;
    int at;
    r.status   = ST_MISS;
    r.position = '0;
    r.data     = '0;
    at = find_key(k_key);
    case (k_kind)
      KIND_UPSERT: begin
        if (at >= 0) begin
          tbl_data[at] = k_pay;
          r.status     = ST_HIT;
          r.position   = 8'(at);
          r.data       = k_pay;
        end else if (tbl_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          tbl_keys[tbl_count] = k_key;
          tbl_data[tbl_count] = k_pay;
          r.status   = ST_INSERTED;
          r.position = 8'(tbl_count);
          r.data     = k_pay;
          tbl_count++;
        end
      end
      KIND_FIND: begin
        if (at >= 0) begin
          r.status   = ST_HIT;
          r.position = 8'(at);
          r.data     = tbl_data[at];
        end
      end
      KIND_RM_KEY: begin
        if (at >= 0) begin
          drop_entry(at);
          r.status   = ST_REMOVED;
          r.position = 8'(at);
        end
      end
      KIND_RM_SLOT: begin
        if (int'(k_slot) < tbl_count) begin
          drop_entry(int'(k_slot));
          r.status   = ST_REMOVED;
          r.position = k_slot;
        end
      end
      KIND_CLEAR: begin
        tbl_count = 0;
        r.status  = ST_CLEARED;
      end
      default: ;
    endcase
    r.occupancy = 9'(tbl_count);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none in calm stretches
  function automatic int pick_idle(input int long_max);
    int r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 199);
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 197) return $urandom_range(4, 24);
    return $urandom_range(40, long_max);
  endfunction

  function automatic logic [63:0] rand_payload();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [31:0] fresh_key();
    logic signed [31:0] k;
    do k = $urandom; while (find_key(k) >= 0);
    return k;
  endfunction

  task automatic send_request(input logic [2:0] k_kind, input logic signed [31:0] k_key,
                              input logic [63:0] k_pay, input logic [7:0] k_slot);
    int gap;
    gap = pick_idle(300);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k_kind;
    key      <= k_key;
    payload  <= k_pay;
    slot     <= k_slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.insert(pending.size(), apply_request(k_kind, k_key, k_pay, k_slot));
    sent_count++;
  endtask

  task automatic test_directed_cases();
    // empty table
    send_request(KIND_FIND, '0, '0, '0);
    send_request(KIND_RM_KEY, KEY_MIN, '0, '0);
    send_request(KIND_RM_SLOT, '0, '0, '0);
    // extreme keys and payloads
    send_request(KIND_UPSERT, KEY_MIN, '1, '1);
    send_request(KIND_UPSERT, KEY_MAX, '0, '0);
    send_request(KIND_UPSERT, -32'sd1, 64'h5555_5555_5555_5555, '0);
    send_request(KIND_UPSERT, '0, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_request(KIND_UPSERT, KEY_MIN, 64'h0123_4567_89AB_CDEF, '0);
    send_request(KIND_FIND, KEY_MAX, '1, '0);
    send_request(KIND_FIND, 32'sh7FFF_FFFE, '0, '0);
    // middle removal pulls the last entry down
    send_request(KIND_RM_SLOT, '0, '0, 8'd1);
    send_request(KIND_FIND, '0, '0, '0);
    // removing the last entry moves nothing
    send_request(KIND_RM_SLOT, '0, '0, 8'd2);
    send_request(KIND_RM_SLOT, '0, '0, 8'hFF);
    send_request(KIND_RM_SLOT, '0, '0, 8'd2);
    send_request(KIND_RM_KEY, KEY_MIN, '0, '0);
    send_request(KIND_FIND, -32'sd1, '0, '0);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      send_request(3'(k), '0, '1, '1);
    end
    send_request(KIND_CLEAR, '1, '1, '1);
    send_request(KIND_FIND, '0, '0, '0);
    send_request(KIND_UPSERT, '0, 64'hFEDC_BA98_7654_3210, '0);
    send_request(KIND_RM_KEY, '0, '0, '0);
  endtask

  task automatic test_fill_to_capacity();
    logic signed [31:0] k;
    send_request(KIND_CLEAR, '0, '0, '0);
    while (tbl_count < CAP) begin
      send_request(KIND_UPSERT, fresh_key(), rand_payload(), 8'($urandom));
    end
    send_request(KIND_UPSERT, fresh_key(), rand_payload(), '0);
    k = tbl_keys[$urandom_range(0, CAP - 1)];
    send_request(KIND_UPSERT, k, rand_payload(), '0);
    send_request(KIND_FIND, tbl_keys[CAP - 1], '0, '0);
    send_request(KIND_RM_SLOT, '0, '0, 8'(CAP - 1));
    send_request(KIND_RM_SLOT, '0, '0, 8'(CAP - 1));
    send_request(KIND_UPSERT, fresh_key(), rand_payload(), '0);
    send_request(KIND_RM_KEY, tbl_keys[$urandom_range(0, CAP - 2)], '0, '0);
    send_request(KIND_RM_SLOT, '0, '0, '0);
    send_request(KIND_FIND, tbl_keys[0], '0, '0);
    send_request(KIND_CLEAR, '0, '0, '0);
  endtask

  task automatic test_random_mix();
    int r;
    logic [2:0] k_kind;
    logic signed [31:0] k_key;
    logic [7:0] k_slot;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_phase = ((n / 50) % 3) == 1;
      r = $urandom_range(0, 99);
      if (r < 40)      k_kind = KIND_UPSERT;
      else if (r < 60) k_kind = KIND_FIND;
      else if (r < 75) k_kind = KIND_RM_KEY;
      else if (r < 90) k_kind = KIND_RM_SLOT;
      else if (r < 94) k_kind = KIND_CLEAR;
      else             k_kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      if ($urandom_range(0, 99) < 85) k_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else k_key = $urandom;
      if ($urandom_range(0, 99) < 70) k_slot = 8'($urandom_range(0, tbl_count));
      else k_slot = 8'($urandom);
      send_request(k_kind, k_key, rand_payload(), k_slot);
    end
    calm_phase = 1'b0;
  endtask

  // Receiver stall: random bursts, with at least one open cycle between them
  initial begin
    int run;
    forever begin
      run = pick_idle(120);
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      reply_count++;
      status_tally[status]++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        fail_count++;
      end else begin
        want = pending.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position);
          fail_count++;
        end
        if (data_out !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, data_out);
          fail_count++;
        end
        if (occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("tb_top: watchdog expired with %0d results outstanding", pending.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_fill_to_capacity();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      fail_count++;
    end
    $display("tb_top: %0d requests sent, %0d results checked, table filled to %0d",
             sent_count, reply_count, CAP);
    $display("tb_top: hit %0d, inserted %0d, removed %0d, miss %0d, full %0d, cleared %0d",
             status_tally[ST_HIT], status_tally[ST_INSERTED], status_tally[ST_REMOVED],
             status_tally[ST_MISS], status_tally[ST_FULL], status_tally[ST_CLEARED]);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/kdt_pkg.sv
hdl/kdt_cell.sv
hdl/kdt_ctrl.sv
hdl/keyed_dense_table_swap_remove_core.sv
tb/tb_top.sv
